>>> rtl/ltrk_pkg.sv
// ----------------------------------------------------------------------------
// Line position tracker package
// Shared widths, register indexes, reset values and Q.8 position codes.
// ----------------------------------------------------------------------------
package ltrk_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int PATTERN_W         = 8;
  localparam int FIELD_W           = 12;
  localparam int FRAC_W            = 8;
  localparam int OUT_DATA_W        = 40;
  localparam int CFG_W             = 5;
  localparam int CFG_IDX_W         = 1;
  localparam int MIN_GRADIENT_LEN  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LEN  = 1'd1;

  localparam logic [CFG_W-1:0] GRADIENT_LEN_RST = 5'd4;
  localparam logic [CFG_W-1:0] AVERAGE_LEN_RST  = 5'd4;

  // -1.0 in Q.8 marks "no mean"
  localparam logic signed [FIELD_W-1:0] NO_MEAN  = -12'sd256;
  localparam logic signed [FIELD_W-1:0] MAX_MEAN = 12'sd1792;

endpackage

>>> rtl/ltrk_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ltrk_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ltrk_div.sv
// ----------------------------------------------------------------------------
// Shared sequential divider
// Signed dividend by positive divisor, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ltrk_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int MAG_W  = DVD_W - 1;
  localparam int ITER_W = $clog2(MAG_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic              neg_q;
  logic [MAG_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVD_W-1:0]  mag_in;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;

  assign mag_in  = dividend_i[DVD_W-1] ? -dividend_i : dividend_i;
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag_in[MAG_W-1:0];
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DVD_W-1];
    end else if (busy_q) begin
      // restore when the trial subtraction borrows
      rem_q <= trial[DVS_W] ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], ~trial[DVS_W]};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

>>> rtl/line_position_history_tracker_core.sv
// ----------------------------------------------------------------------------
// Line position history tracker
// Mean set-bit position of a sensor pattern, kept in a ring of recent means,
// with a gap-aware gradient and an average over the newest entries.
// ----------------------------------------------------------------------------
// Sequence: a mean divide for a nonempty pattern, a walk over the G newest entries with a
//   divide per gap pair, the gradient divide, a walk over the A newest entries and the
//   average divide, G and A the clamped lengths; all divisions share one bit-serial
//   divider that forms 12 + clog2(HISTORY_DEPTH) quotient magnitude bits (16 at depth 16).
// A new item is taken only once the result sits in the output register, so items do not
//   overlap. Reset empties the ring through per-entry valid bits.
module line_position_history_tracker_core #(
  parameter int HISTORY_DEPTH = ltrk_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ltrk_pkg::PATTERN_W-1:0]      s_axis_tdata,   // [7:0] pattern
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] mean_position, [23:12] gradient, [35:24] average_position, zero pad
  output logic [ltrk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [ltrk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ltrk_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int ADDR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W   = ($clog2(HISTORY_DEPTH + 1) > 4) ? $clog2(HISTORY_DEPTH + 1) : 4;
  localparam int SUM_W   = 13 + ADDR_W;
  localparam int FIELD_W = ltrk_pkg::FIELD_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MDIV   = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_G_ADDR = 4'd3;
  localparam logic [3:0] S_G_DATA = 4'd4;
  localparam logic [3:0] S_G_DIV  = 4'd5;
  localparam logic [3:0] S_G_FIN  = 4'd6;
  localparam logic [3:0] S_G_FDIV = 4'd7;
  localparam logic [3:0] S_A_INIT = 4'd8;
  localparam logic [3:0] S_A_ADDR = 4'd9;
  localparam logic [3:0] S_A_DATA = 4'd10;
  localparam logic [3:0] S_A_FIN  = 4'd11;
  localparam logic [3:0] S_A_DIV  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // control state
  logic [3:0]                state_q, state_d;
  logic [ADDR_W-1:0]         newest_q, newest_d, newest_next;
  logic [HISTORY_DEPTH-1:0]  vld_q, vld_d;
  logic [ltrk_pkg::CFG_W-1:0] glen_cfg_q, alen_cfg_q;
  logic                      m_valid_q, m_valid_d;
  logic [CNT_W-1:0]          step_q, step_d, step_inc;
  logic [CNT_W-1:0]          gap_q, gap_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      held_vld_q, held_vld_d;
  logic                      rd_vld_q;

  // datapath
  logic signed [FIELD_W-1:0] mean_q, mean_d;
  logic signed [FIELD_W-1:0] grad_q, grad_d;
  logic signed [FIELD_W-1:0] avg_q, avg_d;
  logic signed [FIELD_W-1:0] older_q, older_d;
  logic signed [FIELD_W-1:0] held_q, held_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [ltrk_pkg::OUT_DATA_W-1:0] m_data_q;
  logic                      out_load;

  // pattern statistics
  logic [3:0]                ones;
  logic [4:0]                idx_sum;

  // clamped lengths and ring addressing
  logic [CNT_W-1:0]          glen, alen;
  logic [CNT_W:0]            addr_wide;
  logic [ADDR_W-1:0]         rd_addr;
  logic [FIELD_W-1:0]        rd_data;
  logic signed [FIELD_W-1:0] hist_val;

  // gradient walk step
  logic                      older_vld, held_vld_nx, pair_ok;
  logic signed [FIELD_W-1:0] held_nx;
  logic [CNT_W-1:0]          gap_nx;
  logic signed [FIELD_W:0]   diff;

  // shared divider
  logic                      div_start, div_done;
  logic signed [SUM_W-1:0]   div_dvd, div_quo;
  logic [CNT_W-1:0]          div_dvs;

  always_comb begin
    ones    = '0;
    idx_sum = '0;
    for (int i = 0; i < ltrk_pkg::PATTERN_W; i++) begin
      if (s_axis_tdata[i]) begin
        ones    = ones + 4'd1;
        idx_sum = idx_sum + 5'(i);
      end
    end
  end

  always_comb begin
    if (32'(glen_cfg_q) > HISTORY_DEPTH) begin
      glen = CNT_W'(HISTORY_DEPTH);
    end else if (32'(glen_cfg_q) < ltrk_pkg::MIN_GRADIENT_LEN) begin
      glen = CNT_W'(ltrk_pkg::MIN_GRADIENT_LEN);
    end else begin
      glen = CNT_W'(glen_cfg_q);
    end
    if (32'(alen_cfg_q) > HISTORY_DEPTH) begin
      alen = CNT_W'(HISTORY_DEPTH);
    end else begin
      alen = CNT_W'(alen_cfg_q);
    end
  end

  // look back step_q entries from the newest slot
  always_comb begin
    if (step_q > CNT_W'(newest_q)) begin
      addr_wide = (CNT_W+1)'(newest_q) + (CNT_W+1)'(HISTORY_DEPTH) - (CNT_W+1)'(step_q);
    end else begin
      addr_wide = (CNT_W+1)'(newest_q) - (CNT_W+1)'(step_q);
    end
  end

  assign rd_addr     = addr_wide[ADDR_W-1:0];
  assign newest_next = (newest_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : newest_q + ADDR_W'(1);
  assign hist_val    = rd_vld_q ? $signed(rd_data) : ltrk_pkg::NO_MEAN;
  assign step_inc    = step_q + CNT_W'(1);

  assign older_vld   = (older_q != ltrk_pkg::NO_MEAN);
  assign held_vld_nx = held_vld_q | older_vld;
  assign held_nx     = older_vld ? older_q : held_q;
  assign gap_nx      = gap_q + CNT_W'(held_vld_nx);
  assign pair_ok     = (hist_val != ltrk_pkg::NO_MEAN) && held_vld_nx;
  assign diff        = {held_nx[FIELD_W-1], held_nx} - {hist_val[FIELD_W-1], hist_val};

  ltrk_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (newest_next),
    .wdata_i (mean_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ltrk_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    newest_d   = newest_q;
    vld_d      = vld_q;
    step_d     = step_q;
    gap_d      = gap_q;
    cnt_d      = cnt_q;
    held_vld_d = held_vld_q;
    mean_d     = mean_q;
    grad_d     = grad_q;
    avg_d      = avg_q;
    older_d    = older_q;
    held_d     = held_q;
    sum_d      = sum_q;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (ones == 4'd0) begin
            mean_d  = ltrk_pkg::NO_MEAN;
            state_d = S_WRITE;
          end else begin
            div_start = 1'b1;
            div_dvd   = SUM_W'({idx_sum, {ltrk_pkg::FRAC_W{1'b0}}});
            div_dvs   = CNT_W'(ones);
            state_d   = S_MDIV;
          end
        end
      end
      S_MDIV: begin
        if (div_done) begin
          mean_d  = div_quo[FIELD_W-1:0];
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        newest_d           = newest_next;
        vld_d[newest_next] = 1'b1;
        step_d             = '0;
        gap_d              = '0;
        cnt_d              = '0;
        sum_d              = '0;
        held_vld_d         = 1'b0;
        state_d            = S_G_ADDR;
      end
      S_G_ADDR: begin
        state_d = S_G_DATA;
      end
      S_G_DATA: begin
        older_d = hist_val;
        step_d  = step_inc;
        if (step_q == '0) begin
          state_d = S_G_ADDR;
        end else begin
          held_d     = held_nx;
          held_vld_d = held_vld_nx;
          gap_d      = gap_nx;
          state_d    = (step_inc == glen) ? S_G_FIN : S_G_ADDR;
          if (pair_ok) begin
            gap_d = '0;
            if (gap_nx == CNT_W'(1)) begin
              sum_d = sum_q + SUM_W'(diff);
              cnt_d = cnt_q + CNT_W'(1);
            end else begin
              // scale the difference by the gap since the held entry
              div_start = 1'b1;
              div_dvd   = SUM_W'(diff);
              div_dvs   = gap_nx;
              state_d   = S_G_DIV;
            end
          end
        end
      end
      S_G_DIV: begin
        if (div_done) begin
          sum_d   = sum_q + div_quo;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = (step_q == glen) ? S_G_FIN : S_G_ADDR;
        end
      end
      S_G_FIN: begin
        if (cnt_q == '0) begin
          grad_d  = '0;
          state_d = S_A_INIT;
        end else begin
          div_start = 1'b1;
          div_dvd   = sum_q;
          div_dvs   = cnt_q;
          state_d   = S_G_FDIV;
        end
      end
      S_G_FDIV: begin
        if (div_done) begin
          grad_d  = div_quo[FIELD_W-1:0];
          state_d = S_A_INIT;
        end
      end
      S_A_INIT: begin
        step_d = '0;
        cnt_d  = '0;
        sum_d  = '0;
        if (alen == '0) begin
          avg_d   = ltrk_pkg::NO_MEAN;
          state_d = S_DONE;
        end else begin
          state_d = S_A_ADDR;
        end
      end
      S_A_ADDR: begin
        state_d = S_A_DATA;
      end
      S_A_DATA: begin
        if (hist_val != ltrk_pkg::NO_MEAN) begin
          sum_d = sum_q + SUM_W'(hist_val);
          cnt_d = cnt_q + CNT_W'(1);
        end
        step_d  = step_inc;
        state_d = (step_inc == alen) ? S_A_FIN : S_A_ADDR;
      end
      S_A_FIN: begin
        if (cnt_q == '0) begin
          avg_d   = ltrk_pkg::NO_MEAN;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_dvd   = sum_q;
          div_dvs   = cnt_q;
          state_d   = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (div_done) begin
          avg_d   = div_quo[FIELD_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      newest_q   <= ADDR_W'(HISTORY_DEPTH - 1);
      vld_q      <= '0;
      glen_cfg_q <= ltrk_pkg::GRADIENT_LEN_RST;
      alen_cfg_q <= ltrk_pkg::AVERAGE_LEN_RST;
      m_valid_q  <= 1'b0;
      step_q     <= '0;
      gap_q      <= '0;
      cnt_q      <= '0;
      held_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      newest_q   <= newest_d;
      vld_q      <= vld_d;
      m_valid_q  <= m_valid_d;
      step_q     <= step_d;
      gap_q      <= gap_d;
      cnt_q      <= cnt_d;
      held_vld_q <= held_vld_d;
      rd_vld_q   <= vld_q[rd_addr];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ltrk_pkg::REG_GRADIENT_LEN: glen_cfg_q <= cfg_data_i;
          ltrk_pkg::REG_AVERAGE_LEN:  alen_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q  <= mean_d;
    grad_q  <= grad_d;
    avg_q   <= avg_d;
    older_q <= older_d;
    held_q  <= held_d;
    sum_q   <= sum_d;
    if (out_load) begin
      m_data_q <= {{(ltrk_pkg::OUT_DATA_W - 3 * FIELD_W){1'b0}}, avg_q, grad_q, mean_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/ltrk_checker.sv
// ----------------------------------------------------------------------------
// Line position tracker checker
// Port-level checks on handshake sequencing and result ranges.
// ----------------------------------------------------------------------------
module ltrk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ltrk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic signed [ltrk_pkg::FIELD_W-1:0] mean_f;
  logic signed [ltrk_pkg::FIELD_W-1:0] avg_f;

  assign mean_f = m_axis_tdata[ltrk_pkg::FIELD_W-1:0];
  assign avg_f  = m_axis_tdata[3*ltrk_pkg::FIELD_W-1:2*ltrk_pkg::FIELD_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an accepted pattern leaves input ready low in the following cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // a new result only appears while an item is in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in work");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> mean_f == ltrk_pkg::NO_MEAN ||
                      (mean_f >= 0 && mean_f <= ltrk_pkg::MAX_MEAN))
    else $error("mean position out of range");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> avg_f == ltrk_pkg::NO_MEAN ||
                      (avg_f >= 0 && avg_f <= ltrk_pkg::MAX_MEAN))
    else $error("average position out of range");

endmodule

bind line_position_history_tracker_core ltrk_checker u_ltrk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
